[rtl/core/y86ifd_pkg.sv]
package y86ifd_pkg;

   // status codes
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_HLT = 2'd1;
   localparam logic [1:0] ST_ADR = 2'd2;
   localparam logic [1:0] ST_INS = 2'd3;

   // instruction classes
   localparam logic [3:0] CL_HALT   = 4'd0;
   localparam logic [3:0] CL_NOP    = 4'd1;
   localparam logic [3:0] CL_CMOV   = 4'd2;
   localparam logic [3:0] CL_IRMOVQ = 4'd3;
   localparam logic [3:0] CL_RMMOVQ = 4'd4;
   localparam logic [3:0] CL_MRMOVQ = 4'd5;
   localparam logic [3:0] CL_OPQ    = 4'd6;
   localparam logic [3:0] CL_JUMP   = 4'd7;
   localparam logic [3:0] CL_CALL   = 4'd8;
   localparam logic [3:0] CL_RET    = 4'd9;
   localparam logic [3:0] CL_PUSHQ  = 4'd10;
   localparam logic [3:0] CL_POPQ   = 4'd11;
   localparam logic [3:0] CL_BAD    = 4'd12;

   // opcode high nibbles
   localparam logic [3:0] OP_HALT   = 4'h0;
   localparam logic [3:0] OP_NOP    = 4'h1;
   localparam logic [3:0] OP_CMOV   = 4'h2;
   localparam logic [3:0] OP_IRMOVQ = 4'h3;
   localparam logic [3:0] OP_RMMOVQ = 4'h4;
   localparam logic [3:0] OP_MRMOVQ = 4'h5;
   localparam logic [3:0] OP_OPQ    = 4'h6;
   localparam logic [3:0] OP_JUMP   = 4'h7;
   localparam logic [3:0] OP_CALL   = 4'h8;
   localparam logic [3:0] OP_RET    = 4'h9;
   localparam logic [3:0] OP_PUSHQ  = 4'hA;
   localparam logic [3:0] OP_POPQ   = 4'hB;

   // highest legal function codes
   localparam logic [3:0] FN_MAX_COND = 4'd6;
   localparam logic [3:0] FN_MAX_ALU  = 4'd3;

   // register field meaning no register
   localparam logic [3:0] NOREG = 4'hF;

   typedef struct packed {
      logic [63:0] fetch_address;
      logic [63:0] window_low;
      logic [15:0] window_high;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  inst_class;
      logic [3:0]  inst_length;
      logic [7:0]  opcode_byte;
      logic [3:0]  function_code;
      logic [3:0]  reg_a;
      logic [3:0]  reg_b;
      logic [63:0] constant_value;
   } rsp_type;

endpackage

[rtl/core/y86_instruction_fetch_decode.sv]
// Y86-64 instruction decoder: takes a fetch address and the ten bytes of memory from that
// address and returns class, length, function code, register fields, constant and status of
// the instruction there. It is a three-stage pipeline (opcode decode, address and field checks,
// result formatting) and takes one instruction every cycle while req_stall is low. Each stage
// holds its beat under rsp_stall and frees as soon as the stage after it moves, so empty slots
// close up and req_stall rises only when all three stages hold beats and the result side is
// stalled. Memory spans addresses 0 to MEM_BYTES-1.
module y86_instruction_fetch_decode
   import y86ifd_pkg::*;
#(
   parameter int MEM_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic        addr_out;
      logic [63:0] pc;
      logic [7:0]  b0;
      logic [3:0]  fn;
      logic [3:0]  size;
      logic [3:0]  cls;
      logic [3:0]  ra;
      logic [3:0]  rb;
      logic [63:0] k;
      logic        bad_regs;
      logic        halt;
   } s1_type;

   typedef struct packed {
      logic [1:0]  st;
      logic [7:0]  b0;
      logic [3:0]  fn;
      logic [3:0]  size;
      logic [3:0]  cls;
      logic [3:0]  ra;
      logic [3:0]  rb;
      logic [63:0] k;
   } s2_type;

   logic    v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic    adv1, adv2, adv3;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   rsp_type out_ff, out_in;

   // stage advance chain, bubbles close up
   assign adv3 = !v3_ff || !rsp_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_stall = !adv1;
   assign rsp_valid = v3_ff;
   assign rsp_data  = out_ff;

   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   // stage 1: opcode decode and fetch address range
   always_comb begin
      logic [7:0] b0;
      logic [7:0] b1;
      logic [3:0] hn;
      logic [3:0] fn;
      b0 = req_data.window_low[7:0];
      b1 = req_data.window_low[15:8];
      hn = b0[7:4];
      fn = b0[3:0];
      s1_in          = '0;
      s1_in.addr_out = req_data.fetch_address >= 64'(MEM_BYTES);
      s1_in.pc       = req_data.fetch_address;
      s1_in.b0       = b0;
      s1_in.fn       = fn;
      s1_in.ra       = NOREG;
      s1_in.rb       = NOREG;
      s1_in.k        = '0;
      s1_in.bad_regs = 1'b0;
      s1_in.halt     = 1'b0;
      case (hn)
         OP_HALT: begin
            s1_in.size = (fn == 4'd0) ? 4'd1 : 4'd0;
            s1_in.cls  = CL_HALT;
            s1_in.halt = 1'b1;
         end
         OP_NOP: begin
            s1_in.size = (fn == 4'd0) ? 4'd1 : 4'd0;
            s1_in.cls  = CL_NOP;
         end
         OP_CMOV: begin
            s1_in.size     = (fn > FN_MAX_COND) ? 4'd0 : 4'd2;
            s1_in.cls      = CL_CMOV;
            s1_in.ra       = b1[7:4];
            s1_in.rb       = b1[3:0];
            s1_in.bad_regs = (b1[7:4] == NOREG) || (b1[3:0] == NOREG);
         end
         OP_IRMOVQ: begin
            s1_in.size     = (fn == 4'd0) ? 4'd10 : 4'd0;
            s1_in.cls      = CL_IRMOVQ;
            s1_in.rb       = b1[3:0];
            s1_in.bad_regs = (b1[7:4] != NOREG) || (b1[3:0] == NOREG);
            s1_in.k        = {req_data.window_high, req_data.window_low[63:16]};
         end
         OP_RMMOVQ, OP_MRMOVQ: begin
            s1_in.size     = (fn == 4'd0) ? 4'd10 : 4'd0;
            s1_in.cls      = (hn == OP_RMMOVQ) ? CL_RMMOVQ : CL_MRMOVQ;
            s1_in.ra       = b1[7:4];
            s1_in.rb       = b1[3:0];
            s1_in.bad_regs = (b1[7:4] == NOREG);
            s1_in.k        = {req_data.window_high, req_data.window_low[63:16]};
         end
         OP_OPQ: begin
            s1_in.size     = (fn > FN_MAX_ALU) ? 4'd0 : 4'd2;
            s1_in.cls      = CL_OPQ;
            s1_in.ra       = b1[7:4];
            s1_in.rb       = b1[3:0];
            s1_in.bad_regs = (b1[7:4] == NOREG) || (b1[3:0] == NOREG);
         end
         OP_JUMP: begin
            s1_in.size = (fn > FN_MAX_COND) ? 4'd0 : 4'd9;
            s1_in.cls  = CL_JUMP;
            s1_in.k    = {req_data.window_high[7:0], req_data.window_low[63:8]};
         end
         OP_CALL: begin
            s1_in.size = (fn == 4'd0) ? 4'd9 : 4'd0;
            s1_in.cls  = CL_CALL;
            s1_in.k    = {req_data.window_high[7:0], req_data.window_low[63:8]};
         end
         OP_RET: begin
            s1_in.size = (fn == 4'd0) ? 4'd1 : 4'd0;
            s1_in.cls  = CL_RET;
         end
         OP_PUSHQ, OP_POPQ: begin
            s1_in.size     = (fn == 4'd0) ? 4'd2 : 4'd0;
            s1_in.cls      = (hn == OP_PUSHQ) ? CL_PUSHQ : CL_POPQ;
            s1_in.ra       = b1[7:4];
            s1_in.bad_regs = (b1[7:4] == NOREG) || (b1[3:0] != NOREG);
         end
         default: begin
            s1_in.size = 4'd0;
            s1_in.cls  = CL_BAD;
         end
      endcase
   end

   // stage 2: end of instruction against memory size, pick status
   always_comb begin
      logic end_over;
      end_over = ({1'b0, s1_ff.pc} + 65'(s1_ff.size)) > 65'(MEM_BYTES);
      s2_in.b0   = s1_ff.b0;
      s2_in.fn   = s1_ff.fn;
      s2_in.size = s1_ff.size;
      s2_in.cls  = s1_ff.cls;
      s2_in.ra   = s1_ff.ra;
      s2_in.rb   = s1_ff.rb;
      s2_in.k    = s1_ff.k;
      if (s1_ff.addr_out) begin
         s2_in.st = ST_ADR;
         s2_in.b0 = '0;
      end else if (s1_ff.size == 4'd0) begin
         s2_in.st = ST_INS;
      end else if (end_over) begin
         s2_in.st = ST_ADR;
      end else if (s1_ff.bad_regs) begin
         s2_in.st = ST_INS;
      end else begin
         s2_in.st = s1_ff.halt ? ST_HLT : ST_OK;
      end
   end

   // stage 3: clear fields of faulting instructions
   always_comb begin
      out_in.status      = s2_ff.st;
      out_in.opcode_byte = s2_ff.b0;
      if (s2_ff.st == ST_ADR || s2_ff.st == ST_INS) begin
         out_in.inst_class     = CL_BAD;
         out_in.inst_length    = 4'd0;
         out_in.function_code  = 4'd0;
         out_in.reg_a          = NOREG;
         out_in.reg_b          = NOREG;
         out_in.constant_value = '0;
      end else begin
         out_in.inst_class     = s2_ff.cls;
         out_in.inst_length    = s2_ff.size;
         out_in.function_code  = s2_ff.fn;
         out_in.reg_a          = s2_ff.ra;
         out_in.reg_b          = s2_ff.rb;
         out_in.constant_value = s2_ff.k;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         s1_ff <= s1_in;
      end
      if (adv2 && v1_ff) begin
         s2_ff <= s2_in;
      end
      if (adv3 && v2_ff) begin
         out_ff <= out_in;
      end
   end

   // accepted beat always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("accepted beat not captured");

   // input held back only when the whole pipe is full and stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && rsp_stall)
      else $error("input stalled with room in the pipe");

   // faulting result carries cleared fields
   a_fault_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_ADR || rsp_data.status == ST_INS)
      |-> rsp_data.inst_class == CL_BAD && rsp_data.inst_length == 4'd0)
      else $error("fault result with live class or length");

   // good result has a real length and a class other than bad or halt
   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_OK |-> rsp_data.inst_length != 4'd0
      && rsp_data.inst_class != CL_BAD && rsp_data.inst_class != CL_HALT)
      else $error("ok result without length or with wrong class");

   // halt result is a one-byte halt
   a_halt_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_HLT
      |-> rsp_data.inst_class == CL_HALT && rsp_data.inst_length == 4'd1)
      else $error("halt status on wrong class or length");

endmodule

[tb/y86_decode_checker.sv]
`timescale 1ns / 1ps

module y86_decode_checker
   import y86ifd_pkg::*;
#(
   parameter int MEM_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      checked_count
);

   rsp_type decode_expected[$];
   rsp_type want;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
   end

   // work out what the decoder should return for one instruction window
   function automatic rsp_type decode_predict(input req_type beat);
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [3:0]  hn;
      logic [3:0]  fn;
      logic [3:0]  size;
      logic [3:0]  cls;
      logic [3:0]  ra;
      logic [3:0]  rb;
      logic [63:0] k;
      logic [1:0]  st;
      logic        fn_bad;
      logic        regs_bad;
      rsp_type     r;

      // error shape, shared by every failing case apart from status and opcode byte
      r.status         = ST_ADR;
      r.inst_class     = CL_BAD;
      r.inst_length    = 4'd0;
      r.opcode_byte    = 8'd0;
      r.function_code  = 4'd0;
      r.reg_a          = NOREG;
      r.reg_b          = NOREG;
      r.constant_value = 64'd0;

      // fetch address outside memory
      if (beat.fetch_address >= 64'(MEM_BYTES))
         return r;

      b0       = beat.window_low[7:0];
      b1       = beat.window_low[15:8];
      hn       = b0[7:4];
      fn       = b0[3:0];
      size     = 4'd0;
      cls      = CL_BAD;
      ra       = NOREG;
      rb       = NOREG;
      k        = 64'd0;
      st       = ST_OK;
      fn_bad   = 1'b0;
      regs_bad = 1'b0;

      case (hn)
         OP_HALT: begin
            size   = 4'd1;
            cls    = CL_HALT;
            st     = ST_HLT;
            fn_bad = (fn != 4'd0);
         end
         OP_NOP: begin
            size   = 4'd1;
            cls    = CL_NOP;
            fn_bad = (fn != 4'd0);
         end
         OP_CMOV: begin
            size     = 4'd2;
            cls      = CL_CMOV;
            fn_bad   = (fn > FN_MAX_COND);
            ra       = b1[7:4];
            rb       = b1[3:0];
            regs_bad = (ra == NOREG) || (rb == NOREG);
         end
         OP_IRMOVQ: begin
            size     = 4'd10;
            cls      = CL_IRMOVQ;
            fn_bad   = (fn != 4'd0);
            rb       = b1[3:0];
            regs_bad = (b1[7:4] != NOREG) || (rb == NOREG);
            k        = {beat.window_high, beat.window_low[63:16]};
         end
         OP_RMMOVQ, OP_MRMOVQ: begin
            size     = 4'd10;
            cls      = (hn == OP_RMMOVQ) ? CL_RMMOVQ : CL_MRMOVQ;
            fn_bad   = (fn != 4'd0);
            ra       = b1[7:4];
            rb       = b1[3:0];
            regs_bad = (ra == NOREG);
            k        = {beat.window_high, beat.window_low[63:16]};
         end
         OP_OPQ: begin
            size     = 4'd2;
            cls      = CL_OPQ;
            fn_bad   = (fn > FN_MAX_ALU);
            ra       = b1[7:4];
            rb       = b1[3:0];
            regs_bad = (ra == NOREG) || (rb == NOREG);
         end
         OP_JUMP, OP_CALL: begin
            size   = 4'd9;
            cls    = (hn == OP_JUMP) ? CL_JUMP : CL_CALL;
            fn_bad = (hn == OP_JUMP) ? (fn > FN_MAX_COND) : (fn != 4'd0);
            k      = {beat.window_high[7:0], beat.window_low[63:8]};
         end
         OP_RET: begin
            size   = 4'd1;
            cls    = CL_RET;
            fn_bad = (fn != 4'd0);
         end
         OP_PUSHQ, OP_POPQ: begin
            size     = 4'd2;
            cls      = (hn == OP_PUSHQ) ? CL_PUSHQ : CL_POPQ;
            fn_bad   = (fn != 4'd0);
            ra       = b1[7:4];
            regs_bad = (ra == NOREG) || (b1[3:0] != NOREG);
         end
         default: begin
            fn_bad = 1'b1;
         end
      endcase

      r.opcode_byte = b0;
      // bad opcode first, then end of instruction, then register fields
      if (fn_bad) begin
         r.status = ST_INS;
         return r;
      end
      if (beat.fetch_address + 64'(size) > 64'(MEM_BYTES)) begin
         r.status = ST_ADR;
         return r;
      end
      if (regs_bad) begin
         r.status = ST_INS;
         return r;
      end

      r.status         = st;
      r.inst_class     = cls;
      r.inst_length    = size;
      r.function_code  = fn;
      r.reg_a          = ra;
      r.reg_b          = rb;
      r.constant_value = k;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   // record accepted requests, compare accepted results in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            decode_expected.push_back(decode_predict(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (decode_expected.size() == 0) begin
               $error("result beat arrived with nothing outstanding");
               fail_count++;
            end else begin
               want = decode_expected.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("inst_class", 64'(want.inst_class), 64'(rsp_data.inst_class));
               check_field("inst_length", 64'(want.inst_length), 64'(rsp_data.inst_length));
               check_field("opcode_byte", 64'(want.opcode_byte), 64'(rsp_data.opcode_byte));
               check_field("function_code", 64'(want.function_code),
                           64'(rsp_data.function_code));
               check_field("reg_a", 64'(want.reg_a), 64'(rsp_data.reg_a));
               check_field("reg_b", 64'(want.reg_b), 64'(rsp_data.reg_b));
               check_field("constant_value", want.constant_value, rsp_data.constant_value);
               checked_count++;
            end
         end
      end
      pending_count = decode_expected.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
   import y86ifd_pkg::*;
;

   localparam int MEM_BYTES   = 4096;
   localparam int CYCLE_LIMIT = 200000;

   // where the 64-bit constant sits in the window
   localparam int K_NONE = 0;
   localparam int K_AT1  = 1;
   localparam int K_AT2  = 2;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count;
   int pending_count;
   int checked_count;
   int cycle_count    = 0;
   int beats_sent     = 0;

   y86_instruction_fetch_decode #(
      .MEM_BYTES(MEM_BYTES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   y86_decode_checker #(
      .MEM_BYTES(MEM_BYTES)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // fill the ten-byte window around the fields that matter
   function automatic req_type make_beat(input logic [63:0] pc, input logic [7:0] b0,
                                         input logic [7:0] b1, input logic [63:0] k,
                                         input int k_at);
      logic [79:0] win;
      req_type     beat;
      win       = {16'($urandom), $urandom, $urandom};
      win[7:0]  = b0;
      if (k_at == K_AT1) begin
         win[71:8] = k;
      end else begin
         win[15:8] = b1;
         if (k_at == K_AT2)
            win[79:16] = k;
      end
      beat.fetch_address = pc;
      beat.window_low    = win[63:0];
      beat.window_high   = win[79:64];
      return beat;
   endfunction

   function automatic logic [3:0] pick_reg();
      return ($urandom_range(99) < 85) ? 4'($urandom_range(14)) : NOREG;
   endfunction

   // present one beat from a falling edge, hold it until taken
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // random instructions, mostly well formed, some noise
   task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                            input bit drain_midway);
      logic [63:0] pc;
      logic [3:0]  hn;
      logic [3:0]  fn;
      logic [3:0]  ra;
      logic [3:0]  rb;
      logic [7:0]  b0;
      int          sel;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         // let the pipe run dry once
         if (drain_midway && i == count / 2) begin
            req_valid <= 1'b0;
            while (pending_count != 0)
               @(negedge clock);
         end
         sel = $urandom_range(99);
         if (sel < 78)
            pc = 64'($urandom_range(MEM_BYTES - 1));
         else if (sel < 92)
            pc = 64'(MEM_BYTES - 1 - $urandom_range(11));
         else if (sel < 95)
            pc = 64'(MEM_BYTES);
         else
            pc = {$urandom, $urandom};
         hn = 4'($urandom_range(11));
         case (hn)
            OP_CMOV, OP_JUMP: fn = 4'($urandom_range(FN_MAX_COND));
            OP_OPQ:           fn = 4'($urandom_range(FN_MAX_ALU));
            default:          fn = 4'd0;
         endcase
         ra = pick_reg();
         rb = pick_reg();
         if (hn == OP_IRMOVQ && $urandom_range(9) != 0)
            ra = NOREG;
         if ((hn == OP_PUSHQ || hn == OP_POPQ) && $urandom_range(9) != 0)
            rb = NOREG;
         b0 = {hn, fn};
         if ($urandom_range(99) < 12)
            b0 = 8'($urandom);
         send_beat(make_beat(pc, b0, {ra, rb}, 64'd0, K_NONE));
      end
   endtask

   // stimulus
   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: every class, bad function and register fields, memory edges
      send_beat(make_beat(64'd0, {OP_HALT, 4'd0}, 8'h00, 64'd0, K_NONE));
      send_beat(make_beat(64'd1, {OP_HALT, 4'd1}, 8'h00, 64'd0, K_NONE));
      send_beat(make_beat(64'd2, {OP_NOP, 4'd0}, 8'h00, 64'd0, K_NONE));
      send_beat(make_beat(64'd3, {OP_CMOV, 4'd0}, {4'd3, 4'd7}, 64'd0, K_NONE));
      send_beat(make_beat(64'd5, {OP_CMOV, FN_MAX_COND}, {4'd0, 4'd14}, 64'd0, K_NONE));
      send_beat(make_beat(64'd7, {OP_CMOV, 4'd7}, {4'd1, 4'd1}, 64'd0, K_NONE));
      send_beat(make_beat(64'd9, {OP_IRMOVQ, 4'd0}, {NOREG, 4'd2}, '1, K_AT2));
      send_beat(make_beat(64'd19, {OP_IRMOVQ, 4'd0}, {4'd1, 4'd2}, 64'd5, K_AT2));
      send_beat(make_beat(64'd29, {OP_IRMOVQ, 4'd0}, {NOREG, NOREG}, 64'd5, K_AT2));
      send_beat(make_beat(64'd39, {OP_RMMOVQ, 4'd0}, {4'd0, NOREG}, 64'd0, K_AT2));
      send_beat(make_beat(64'd49, {OP_MRMOVQ, 4'd0}, {NOREG, 4'd5}, 64'd9, K_AT2));
      send_beat(make_beat(64'd59, {OP_MRMOVQ, 4'd0}, {4'd14, NOREG},
                          64'h8000_0000_0000_0000, K_AT2));
      send_beat(make_beat(64'd69, {OP_OPQ, FN_MAX_ALU}, {4'd14, 4'd0}, 64'd0, K_NONE));
      send_beat(make_beat(64'd71, {OP_OPQ, 4'd4}, {4'd2, 4'd3}, 64'd0, K_NONE));
      send_beat(make_beat(64'd73, {OP_JUMP, FN_MAX_COND}, 8'h00, '1, K_AT1));
      send_beat(make_beat(64'd82, {OP_CALL, 4'd0}, 8'h00, 64'd0, K_AT1));
      send_beat(make_beat(64'd91, {OP_RET, 4'd0}, 8'h00, 64'd0, K_NONE));
      send_beat(make_beat(64'd92, {OP_PUSHQ, 4'd0}, {4'd4, NOREG}, 64'd0, K_NONE));
      send_beat(make_beat(64'd94, {OP_PUSHQ, 4'd0}, {4'd4, 4'd3}, 64'd0, K_NONE));
      send_beat(make_beat(64'd96, {OP_POPQ, 4'd0}, {NOREG, NOREG}, 64'd0, K_NONE));
      send_beat(make_beat(64'd98, 8'hC0, 8'h00, 64'd0, K_NONE));
      send_beat(make_beat(64'(MEM_BYTES - 1), {OP_HALT, 4'd0}, 8'h00, 64'd0, K_NONE));
      send_beat(make_beat(64'(MEM_BYTES - 2), {OP_IRMOVQ, 4'd0}, {NOREG, 4'd1}, 64'd1,
                          K_AT2));
      send_beat(make_beat(64'(MEM_BYTES - 10), {OP_IRMOVQ, 4'd0}, {NOREG, 4'd1}, '1,
                          K_AT2));
      send_beat(make_beat(64'(MEM_BYTES - 1), {OP_PUSHQ, 4'd0}, {NOREG, 4'd3}, 64'd0,
                          K_NONE));
      send_beat(make_beat(64'(MEM_BYTES - 1), 8'hC0, 8'h00, 64'd0, K_NONE));
      send_beat(make_beat(64'(MEM_BYTES), {OP_NOP, 4'd0}, 8'h00, 64'd0, K_NONE));
      send_beat(make_beat('1, {OP_NOP, 4'd0}, 8'h00, 64'd0, K_NONE));

      // random: sender idles lightly, then receiver, then flat out
      run_phase(15, 49, 330, 1'b1);
      run_phase(49, 15, 330, 1'b0);
      run_phase(0, 0, 340, 1'b0);

      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      $display("%0d instructions sent, %0d decode results checked", beats_sent,
               checked_count);
      $display("covered all classes, bad fields, memory edges and mixed back-pressure");
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[y86_instruction_fetch_decode.f]
rtl/core/y86ifd_pkg.sv
rtl/core/y86_instruction_fetch_decode.sv
tb/y86_decode_checker.sv
tb/tb_top.sv
